/* rtl/bhenc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhenc_pkg
// Shared types, codes and character tables for the hex / base64 text encoder.
// ----------------------------------------------------------------------------
package bhenc_pkg;

  // Encoding select codes
  localparam logic ENC_HEX = 1'b0;
  localparam logic ENC_B64 = 1'b1;

  // Base64 group phase codes (bytes already taken in the current group)
  localparam logic [1:0] PHASE_START = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_TWO   = 2'd2;

  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned JOB_LEN = 4;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [CHAR_W-1:0] CHAR_PAD = 7'h3d;  // '='

  // One classified byte: up to four characters and the index of the final one
  typedef struct packed {
    logic [JOB_LEN-1:0][CHAR_W-1:0] chars;
    logic [1:0]                     last_idx;
  } job_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, v};
    if (v < 4'd10) return ext + 7'h30;   // '0'..'9'
    else           return ext + 7'h57;   // 'a'..'f'
  endfunction

  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
    logic [CHAR_W-1:0] ext;
    ext = {1'b0, v};
    if (v < 6'd26)      return ext + 7'h41;  // 'A'..'Z'
    else if (v < 6'd52) return ext + 7'h47;  // 'a'..'z'
    else if (v < 6'd62) return ext - 7'h04;  // '0'..'9'
    else if (v == 6'd62) return 7'h2b;       // '+'
    else                return 7'h2f;        // '/'
  endfunction

endpackage

/* rtl/bhenc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhenc_front
// Accepts bytes, tracks the base64 group state and builds one character job.
// ----------------------------------------------------------------------------
module bhenc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                enc_sel,
  input  logic                in_push,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  input  logic                q_full,
  output logic                q_push,
  output bhenc_pkg::job_t     q_job
);
  import bhenc_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  job_t       job;

  assign q_push = in_push && !q_full;
  assign q_job  = job;

  always_comb begin
    job.chars    = '{default: CHAR_PAD};
    job.last_idx = 2'd0;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    if (enc_sel == ENC_HEX) begin
      job.chars[0] = hex_char(in_data_byte[7:4]);
      job.chars[1] = hex_char(in_data_byte[3:0]);
      job.last_idx = 2'd1;
      phase_nxt    = PHASE_START;
      left_nxt     = 4'd0;
    end else begin
      case (phase_r)
        PHASE_ONE: begin
          job.chars[0] = b64_char({left_r[1:0], in_data_byte[7:4]});
          job.chars[1] = b64_char({in_data_byte[3:0], 2'b00});
          job.last_idx = in_last_byte ? 2'd2 : 2'd0;
          phase_nxt    = PHASE_TWO;
          left_nxt     = in_data_byte[3:0];
        end
        PHASE_TWO: begin
          job.chars[0] = b64_char({left_r, in_data_byte[7:6]});
          job.chars[1] = b64_char(in_data_byte[5:0]);
          job.last_idx = 2'd1;
          phase_nxt    = PHASE_START;
          left_nxt     = 4'd0;
        end
        default: begin
          job.chars[0] = b64_char(in_data_byte[7:2]);
          job.chars[1] = b64_char({in_data_byte[1:0], 4'b0000});
          job.last_idx = in_last_byte ? 2'd3 : 2'd0;
          phase_nxt    = PHASE_ONE;
          left_nxt     = {2'b00, in_data_byte[1:0]};
        end
      endcase
      if (in_last_byte) begin
        phase_nxt = PHASE_START;
        left_nxt  = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_START;
      left_r  <= 4'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

/* rtl/bhenc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhenc_queue
// Two-entry job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module bhenc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bhenc_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output bhenc_pkg::job_t head_job
);
  import bhenc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

/* rtl/bhenc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhenc_back
// Walks the head job to the output reg, one char per cycle unless stalled.
// ----------------------------------------------------------------------------
module bhenc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  bhenc_pkg::job_t               q_head,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bhenc_pkg::CHAR_W-1:0]  out_text_char,
  output logic                          out_end_of_text
);
  import bhenc_pkg::*;

  logic              valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              eot_r;
  logic [1:0]        idx_r, idx_nxt;
  logic              load, at_end;

  assign load    = (!valid_r || out_pop) && !q_empty;
  assign at_end  = (idx_r == q_head.last_idx);
  assign q_pop   = load && at_end;
  assign idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;

  assign out_empty       = !valid_r;
  assign out_text_char   = char_r;
  assign out_end_of_text = eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load)              valid_r <= 1'b1;
      else if (out_pop)      valid_r <= 1'b0;
      if (load)              idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= q_head.chars[idx_r];
      eot_r  <= at_end;
    end
  end

endmodule

/* rtl/byte_to_hex_or_base64_encoder_top.sv */
`timescale 1ns / 1ps
// Path: a byte accepted into the job queue moves from there into the output
//   register, which drives the result ports.
// Output: one character per cycle from the output register while the reader
//   takes them; a hex byte is 2 characters, base64 1 to 4 (4 per full group).
// Reset: synchronous, active low; clears the queue, the output register, the
//   base64 group phase and leftover bits, and selects hex encoding.
// ----------------------------------------------------------------------------
// byte_to_hex_or_base64_encoder_top
// Byte stream to lowercase hex or padded base64 ASCII text.
// ----------------------------------------------------------------------------
module byte_to_hex_or_base64_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input queue side
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  // character output queue side
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bhenc_pkg::CHAR_W-1:0]  out_text_char,
  output logic                          out_end_of_text,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_encoding_select
);
  import bhenc_pkg::*;

  logic enc_sel_r;
  logic q_push, q_pop, q_full, q_empty;
  job_t q_job, q_head;

  // The register must only be written while idle, which the user ensures, so take every word at once.
  assign cfg_ready = 1'b1;

  // Hold the encoding select; the base64 group state lives in the front end
  // and is kept across a mode change, but each hex byte clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_sel_r <= ENC_HEX;
    end else if (cfg_valid && cfg_ready) begin
      enc_sel_r <= cfg_encoding_select;
    end
  end

  // Back-pressure to the byte source comes only from the job queue, so a byte
  // may enter while characters of earlier bytes still drain.
  assign in_full = q_full;

  // Front end: classify the byte against the group phase and build its
  // character job (up to four characters, '=' padding to close a base64 group).
  bhenc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .enc_sel      (enc_sel_r),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // Short job queue decoupling the two sides.
  bhenc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_job (q_head)
  );

  // Back end: advance through the head job one character per word taken,
  // flag the final character of each job, then drop the job.
  bhenc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_text_char   (out_text_char),
    .out_end_of_text (out_end_of_text)
  );

endmodule

/* rtl/bhenc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhenc_checker
// Port-level checks for the encoder top level, bound in below.
// ----------------------------------------------------------------------------
module bhenc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_full,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic [bhenc_pkg::CHAR_W-1:0]  out_text_char,
  input logic                          out_end_of_text
);
  import bhenc_pkg::*;

  // A waiting word holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_text_char)
                                  && $stable(out_end_of_text)))
    else $error("result word changed while stalled");

  // Every character lies in '+'..'z', which spans hex, base64 and padding.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_text_char >= 7'h2b && out_text_char <= 7'h7a))
    else $error("character outside the encoding alphabets");

  // A padding character not ending its run is followed by a second one.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_text_char == CHAR_PAD && !out_end_of_text)
      |=> (!out_empty && out_text_char == CHAR_PAD && out_end_of_text))
    else $error("padding run broken");

  // Coming out of reset nothing is waiting and bytes are taken.
  a_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (out_empty && !in_full))
    else $error("queues not clear after reset");

endmodule

bind byte_to_hex_or_base64_encoder_top bhenc_checker u_bhenc_checker (.*);
